>>> design/integral_histogram_stream_unit_macros.svh
// assertion macros used by the port checker
`ifndef INTEGRAL_HISTOGRAM_STREAM_UNIT_MACROS_SVH
`define INTEGRAL_HISTOGRAM_STREAM_UNIT_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define IHS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define IHS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs during reset
`define IHS_ASSERT_ALWAYS_NEXT(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ihs_pkg.sv
// shared types, register indexes and helpers of the integral histogram unit
package ihs_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BINS_IN_USE  = 2'd2
  } ihs_cfg_idx_t;

  localparam int CFG_W       = 11;
  localparam int BINS_W      = 5;
  localparam int LABEL_W     = 6;
  localparam int COUNT_W     = 21;
  localparam int RUN_W       = 11;
  localparam int BIN_INDEX_W = 4;
  // row store address, sized for the largest width times bins
  localparam int BASE_W      = 18;
  // limit operand, sized for the largest frame dimension
  localparam int LIMIT_W     = 13;

  // one classified pixel, front to back
  typedef struct packed {
    logic [BASE_W-1:0]  base;      // first row store slot of the column
    logic [LABEL_W-1:0] bin_sel;   // zero-based bin, meaningful when not bad
    logic               bad;       // label out of range, not counted
    logic               fend;      // last pixel of the frame
    logic               col_zero;  // first pixel of a row
    logic               row_zero;  // first row, row above reads as zero
  } ihs_item_t;

  // zero reads as one, values above the limit saturate
  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [LIMIT_W-1:0] hi);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (LIMIT_W'(v) > hi) begin
      res = CFG_W'(hi);
    end
    return res;
  endfunction

endpackage

>>> design/ihs_ram.sv
// generic single-write, single-read RAM with registered read data
module ihs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ihs_front.sv
// front end: accepts pixels, tracks position and classifies each label
module ihs_front import ihs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int NUM_BINS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CFG_W-1:0]   width,
  input  logic [CFG_W-1:0]   height,
  input  logic [BINS_W-1:0]  nb,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [LABEL_W-1:0] bin_label,
  input  logic               full,
  output logic               push,
  output ihs_item_t          item
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic          last_col;
  logic          last_row;

  // position beyond a shrunken frame falls back to zero
  always_comb begin
    col_eff  = (LIMIT_W'(col) >= LIMIT_W'(width)) ? '0 : col;
    row_eff  = (LIMIT_W'(row) >= LIMIT_W'(height)) ? '0 : row;
    last_col = (LIMIT_W'(col_eff) + LIMIT_W'(1)) >= LIMIT_W'(width);
    last_row = (LIMIT_W'(row_eff) + LIMIT_W'(1)) >= LIMIT_W'(height);
  end

  // classify the pixel
  always_comb begin
    item.base     = BASE_W'(col_eff * NUM_BINS);
    item.bin_sel  = bin_label - LABEL_W'(1);
    item.bad      = (bin_label == '0) || (bin_label > LABEL_W'(nb));
    item.fend     = last_col && last_row;
    item.col_zero = (col_eff == '0);
    item.row_zero = (row_eff == '0);
  end

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  // raster position, wraps at row and frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : RW'(row_eff + RW'(1));
      end else begin
        col <= CW'(col_eff + CW'(1));
        row <= row_eff;
      end
    end
  end

endmodule

>>> design/ihs_queue.sv
// short queue of classified pixels between front and back
module ihs_queue import ihs_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ihs_item_t din,
  input  logic      pop,
  output ihs_item_t dout,
  output logic      full,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  ihs_item_t      slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  fill;

  assign full  = (fill == NW'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + PW'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + PW'(1));
      end
      if (push && !pop) begin
        fill <= NW'(fill + NW'(1));
      end else if (pop && !push) begin
        fill <= NW'(fill - NW'(1));
      end
    end
  end

endmodule

>>> design/ihs_back.sv
// back end: walks the bins of each pixel through the row store
module ihs_back import ihs_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int NUM_BINS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [BINS_W-1:0]      nb,
  input  ihs_item_t              item,
  input  logic                   empty,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [BIN_INDEX_W-1:0] bin_index,
  output logic [COUNT_W-1:0]     prefix_count,
  output logic                   last_bin,
  output logic                   bad_label,
  output logic                   frame_end
);

  localparam int KW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int DEPTH = MAX_WIDTH * NUM_BINS;
  localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int NBW   = BINS_W + 1;

  // running counts of the current row
  logic [RUN_W-1:0]   run [NUM_BINS];

  // issue side
  logic [KW-1:0]      k_iss;
  logic               k_last;
  logic               issue;
  logic [AW-1:0]      raddr;

  // read-pending stage
  logic               pend;
  logic [KW-1:0]      pend_k;
  logic [AW-1:0]      pend_addr;
  logic               pend_last;
  logic               pend_bad;
  logic               pend_fend;
  logic               pend_row0;
  logic               fwd_hit;
  logic [COUNT_W-1:0] fwd_data;

  // row store and result path
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] above;
  logic [COUNT_W-1:0] total;
  logic               adv;
  logic               cons;

  assign adv    = !m_tvalid || m_tready;
  assign cons   = pend && adv;
  assign issue  = !empty && (!pend || adv);
  assign k_last = (NBW'(k_iss) + NBW'(1)) == NBW'(nb);
  assign pop    = issue && k_last;
  assign raddr  = AW'(item.base) + AW'(k_iss);

  // count from the row above plus this row's running count
  always_comb begin
    if (pend_row0) begin
      above = '0;
    end else if (fwd_hit) begin
      above = fwd_data;
    end else begin
      above = ram_rdata;
    end
    total = COUNT_W'(above + COUNT_W'(run[pend_k]));
  end

  ihs_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (cons),
    .waddr (pend_addr),
    .wdata (total),
    .re    (issue),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // running counts update when a pixel starts its first bin
  always_ff @(posedge clk) begin
    if (issue && (k_iss == '0)) begin
      for (int j = 0; j < NUM_BINS; j++) begin
        if (!item.bad && (LABEL_W'(j) == item.bin_sel)) begin
          run[j] <= item.col_zero ? RUN_W'(1) : RUN_W'(run[j] + RUN_W'(1));
        end else if (item.col_zero) begin
          run[j] <= '0;
        end
      end
    end
  end

  // bin counter
  always_ff @(posedge clk) begin
    if (rst) begin
      k_iss <= '0;
    end else if (issue) begin
      k_iss <= k_last ? '0 : KW'(k_iss + KW'(1));
    end
  end

  // read-pending stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (issue) begin
      pend <= 1'b1;
    end else if (cons) begin
      pend <= 1'b0;
    end
  end

  // read-pending payload, with bypass of a write to the slot being read
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_k    <= k_iss;
      pend_addr <= raddr;
      pend_last <= k_last;
      pend_bad  <= item.bad;
      pend_fend <= item.fend;
      pend_row0 <= item.row_zero;
      fwd_hit   <= cons && (pend_addr == raddr);
      fwd_data  <= total;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (cons) begin
      bin_index    <= BIN_INDEX_W'(pend_k);
      prefix_count <= total;
      last_bin     <= pend_last;
      bad_label    <= pend_bad;
      frame_end    <= pend_fend;
    end
  end

endmodule

>>> design/integral_histogram_stream_unit.sv
// Integral histogram over a raster pixel stream. Each accepted pixel label
// yields bins_in_use results, one per bin, carrying the count of pixels of
// that bin from the frame origin to the pixel; tlast marks the final result
// of the pixel. The back end delivers one result per cycle while pixels wait
// and m_tready is high, set by the single read and single write port of the
// previous-row store, which each bin reads and writes back once. The front
// end accepts a pixel per cycle into a two-entry queue and stalls only when
// that queue is full. The row store needs no clearing pass after reset: the
// first row reads zero. Registers are written only while idle through
// cfg_we/cfg_index/cfg_wdata, which the user, not the block, enforces.
module integral_histogram_stream_unit import ihs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int NUM_BINS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // pixel stream in
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [5:0] bin_label
  // result stream out
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [3:0] bin_index, [24:4] prefix_count
  output logic              m_tlast,   // last_bin
  output logic [1:0]        m_tuser    // [0] bad_label, [1] frame_end
);

  logic [CFG_W-1:0]       image_width;
  logic [CFG_W-1:0]       image_height;
  logic [BINS_W-1:0]      bins_in_use;
  logic [CFG_W-1:0]       width_eff;
  logic [CFG_W-1:0]       height_eff;
  logic [BINS_W-1:0]      nb_eff;

  ihs_item_t              push_item;
  ihs_item_t              head_item;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;

  logic [BIN_INDEX_W-1:0] bin_index;
  logic [COUNT_W-1:0]     prefix_count;
  logic                   bad_label;
  logic                   frame_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1024);
      image_height <= CFG_W'(1024);
      bins_in_use  <= BINS_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        CFG_BINS_IN_USE:  bins_in_use  <= cfg_wdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective register values
  assign width_eff  = clamp_cfg(image_width, LIMIT_W'(MAX_WIDTH));
  assign height_eff = clamp_cfg(image_height, LIMIT_W'(MAX_HEIGHT));
  assign nb_eff     = BINS_W'(clamp_cfg(CFG_W'(bins_in_use), LIMIT_W'(NUM_BINS)));

  ihs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .NUM_BINS   (NUM_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .width     (width_eff),
    .height    (height_eff),
    .nb        (nb_eff),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .bin_label (s_tdata[LABEL_W-1:0]),
    .full      (full),
    .push      (push),
    .item      (push_item)
  );

  ihs_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_item),
    .pop   (pop),
    .dout  (head_item),
    .full  (full),
    .empty (empty)
  );

  ihs_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .NUM_BINS  (NUM_BINS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .nb           (nb_eff),
    .item         (head_item),
    .empty        (empty),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .bin_index    (bin_index),
    .prefix_count (prefix_count),
    .last_bin     (m_tlast),
    .bad_label    (bad_label),
    .frame_end    (frame_end)
  );

  // pack the result transaction
  assign m_tdata = {7'b0, prefix_count, bin_index};
  assign m_tuser = {frame_end, bad_label};

endmodule

>>> design/ihs_check.sv
// port checker of the integral histogram unit, bound to the top level
`include "integral_histogram_stream_unit_macros.svh"

module ihs_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  logic [3:0] exp_bin;
  logic       mid_pixel;
  logic [1:0] pixel_user;

  // expected bin of the next result and flags of the pixel in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_bin   <= '0;
      mid_pixel <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      exp_bin   <= m_tlast ? 4'd0 : 4'(m_tdata[3:0] + 4'd1);
      mid_pixel <= !m_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      pixel_user <= m_tuser;
    end
  end

  `IHS_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, rst, !m_tvalid, "result valid after reset")
  `IHS_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")
  `IHS_ASSERT_NOW(a_bin_order, clk, rst, m_tvalid, m_tdata[3:0] == exp_bin, "bins out of order")
  `IHS_ASSERT_NOW(a_pixel_flags, clk, rst, m_tvalid && mid_pixel, m_tuser == pixel_user, "flags changed within a pixel")

endmodule

bind integral_histogram_stream_unit ihs_check u_check (.*);
